>>> src/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types, constants and fixed-point helpers for the mesh closest-hit block.
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DVD_W     = 32 + FRAC_BITS;   // magnitude of n * ONE
  localparam int QW        = DVD_W + 1;        // signed quotient

  typedef enum logic [1:0] {
    CMD_POS   = 2'd0,
    CMD_NRM   = 2'd1,
    CMD_TRI   = 2'd2,
    CMD_TRACE = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_TRI_COUNT = 2'd0;
  localparam logic [1:0] REG_EPSILON   = 2'd1;

  localparam logic [4:0] STEP_TEST_LAST = 5'd23;
  localparam logic [4:0] STEP_HIT_FIRST = 5'd24;
  localparam logic [4:0] STEP_HIT_LAST  = 5'd26;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef enum logic [2:0] {
    K_CROSS_FIRST,
    K_CROSS_END,
    K_DOT_FIRST,
    K_DOT_MID,
    K_DOT_END,
    K_HIT
  } acc_kind_t;

  typedef struct packed {
    acc_kind_t  kind;
    logic [2:0] dst;
  } acc_op_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // floor shift of a product to Q16.16
  function automatic logic signed [64:0] fsh(input logic signed [63:0] p);
    logic signed [64:0] e;
    e = 65'(p);
    return e >>> FRAC_BITS;
  endfunction

  // Steps 0-11: cross products, pairs (first product, then subtract).
  // Steps 12-23: four dot products, three terms each. Steps 24-26: hit point.
  function automatic acc_op_t acc_op(input logic [4:0] step);
    acc_op_t r;
    r.dst = 3'(step[4:1]);
    case (step)
      5'd12, 5'd15, 5'd18, 5'd21: r.kind = K_DOT_FIRST;
      5'd13, 5'd16, 5'd19, 5'd22: r.kind = K_DOT_MID;
      5'd14: begin r.kind = K_DOT_END; r.dst = 3'd0; end
      5'd17: begin r.kind = K_DOT_END; r.dst = 3'd1; end
      5'd20: begin r.kind = K_DOT_END; r.dst = 3'd2; end
      5'd23: begin r.kind = K_DOT_END; r.dst = 3'd3; end
      5'd24: begin r.kind = K_HIT; r.dst = 3'd0; end
      5'd25: begin r.kind = K_HIT; r.dst = 3'd1; end
      5'd26: begin r.kind = K_HIT; r.dst = 3'd2; end
      default: r.kind = step[0] ? K_CROSS_END : K_CROSS_FIRST;
    endcase
    return r;
  endfunction

endpackage

>>> src/rtc_div.sv
// ----------------------------------------------------------------------------
// rtc_div
// Signed (n << FRAC_BITS) / d, truncated toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rtc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [32:0]               num,
  input  logic signed [31:0]               den,
  output logic                             done,
  output logic signed [rtc_pkg::QW-1:0]    quo
);

  localparam int CW = $clog2(rtc_pkg::DVD_W + 1);

  logic                        run;
  logic [CW-1:0]               cnt;
  logic [32:0]                 rem;
  logic [rtc_pkg::DVD_W-1:0]   dvd;
  logic [31:0]                 dmag;
  logic                        neg;

  logic [32:0]                 nabs;
  logic [31:0]                 dabs;
  logic [32:0]                 rem_sh;
  logic                        ge;
  logic [32:0]                 rem_nx;
  logic [rtc_pkg::DVD_W-1:0]   dvd_nx;

  assign nabs   = num[32] ? 33'(-num) : 33'(num);
  assign dabs   = den[31] ? 32'(-den) : 32'(den);
  assign rem_sh = {rem[31:0], dvd[rtc_pkg::DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dmag};
  assign rem_nx = ge ? (rem_sh - {1'b0, dmag}) : rem_sh;
  assign dvd_nx = {dvd[rtc_pkg::DVD_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= CW'(rtc_pkg::DVD_W);
        rem  <= '0;
        dvd  <= {nabs[31:0], {rtc_pkg::FRAC_BITS{1'b0}}};
        dmag <= dabs;
        neg  <= num[32] ^ den[31];
      end else if (run) begin
        rem <= rem_nx;
        dvd <= dvd_nx;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
          quo  <= neg ? -$signed(rtc_pkg::QW'(dvd_nx)) : $signed(rtc_pkg::QW'(dvd_nx));
        end
      end
    end
  end

endmodule

>>> src/ray_triangle_mesh_closest_hit.sv
// ----------------------------------------------------------------------------
// ray_triangle_mesh_closest_hit
// Triangle mesh store with a Cramer's-rule closest-hit ray test in Q16.16.
// ----------------------------------------------------------------------------
// Write commands: result strobe in the cycle after the start beat; busy stays low.
// Trace: per triangle, a load of the corner indices and vertices and the shared
// multiplier steps, then up to three divisions on the one divider (48 quotient
// bits, one a cycle); on a hit, the hit point on the multiplier, then the result.
// One item at a time; the result strobe cannot be stalled.
// Reset clears control and the triangle count and sets epsilon to 7; mesh memories are undefined until written.
module ray_triangle_mesh_closest_hit #(
  parameter int MAX_TRIANGLES = 1024,
  parameter int MAX_VERTICES  = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [10:0]        entry,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic [10:0]        corner_a,
  input  logic [10:0]        corner_b,
  input  logic [10:0]        corner_c,
  input  logic [30:0]        max_distance,
  output logic               done,
  output logic               hit,
  output logic [30:0]        hit_distance,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y,
  output logic signed [31:0] hit_z,
  output logic signed [31:0] normal_x,
  output logic signed [31:0] normal_y,
  output logic signed [31:0] normal_z,
  output logic [9:0]         tri_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  localparam int VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int TI = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int TC = $clog2(MAX_TRIANGLES + 1);
  localparam logic signed [rtc_pkg::QW-1:0] ONE_Q =
    rtc_pkg::QW'(1) <<< rtc_pkg::FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_TRI, S_VA, S_VB, S_VC, S_SUB, S_MUL, S_DRAIN,
    S_CHK, S_DIV, S_NEXT, S_FIN, S_HP, S_HPDRAIN, S_OUT
  } state_t;

  state_t state;

  // config
  logic [10:0] tri_count;
  logic [16:0] epsilon;

  // memories
  rtc_pkg::vec_t pos_mem [MAX_VERTICES];
  rtc_pkg::vec_t nrm_mem [MAX_VERTICES];
  logic [32:0]   tri_mem [MAX_TRIANGLES];
  rtc_pkg::vec_t pos_q;
  rtc_pkg::vec_t nrm_q;
  logic [32:0]   tri_q;

  logic          accept;
  logic          pos_we, nrm_we, tri_we, pos_re, nrm_re, tri_re;
  logic [VA-1:0] pos_raddr;

  // per-ray and per-triangle registers
  rtc_pkg::vec_t org, dv, va, vb, ab, ac, ao, c1, c2;
  logic [10:0]   crn_b, crn_c, crn_a;
  logic          ok_a, ok_b, ok_c;
  logic [TC-1:0] idx, count;
  logic [30:0]   best;
  logic [TI-1:0] best_i;
  logic [10:0]   best_a;
  logic          found;
  logic [1:0]    sel;
  logic signed [rtc_pkg::QW-1:0] t_q, u_q;
  logic signed [31:0] dotr [4];
  logic signed [31:0] hp [3];
  rtc_pkg::vec_t vc;

  // shared multiplier
  logic [4:0]          step, acc_step;
  logic                acc_en, issue;
  logic signed [31:0]  ma, mb;
  logic signed [63:0]  prod;
  logic signed [64:0]  acc;
  rtc_pkg::acc_op_t    aop;
  logic signed [31:0]  cross_val;

  // divider
  logic                          div_start, div_done;
  logic signed [32:0]            div_num;
  logic signed [rtc_pkg::QW-1:0] quo;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign pos_we = accept && (cmd == rtc_pkg::CMD_POS) && (32'(entry) < MAX_VERTICES);
  assign nrm_we = accept && (cmd == rtc_pkg::CMD_NRM) && (32'(entry) < MAX_VERTICES);
  assign tri_we = accept && (cmd == rtc_pkg::CMD_TRI) && (32'(entry) < MAX_TRIANGLES);
  assign tri_re = (state == S_TRI);
  assign pos_re = (state == S_VA) || (state == S_VB) || (state == S_VC);
  assign nrm_re = (state == S_FIN);

  always_comb begin
    case (state)
      S_VA:    pos_raddr = VA'(tri_q[10:0]);
      S_VB:    pos_raddr = VA'(crn_b);
      default: pos_raddr = VA'(crn_c);
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[VA'(entry)] <= {coord_x, coord_y, coord_z};
    end
    if (pos_re) begin
      pos_q <= pos_mem[pos_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (nrm_we) begin
      nrm_mem[VA'(entry)] <= {coord_x, coord_y, coord_z};
    end
    if (nrm_re) begin
      nrm_q <= nrm_mem[VA'(best_a)];
    end
  end

  always_ff @(posedge clk) begin
    if (tri_we) begin
      tri_mem[TI'(entry)] <= {corner_c, corner_b, corner_a};
    end
    if (tri_re) begin
      tri_q <= tri_mem[idx[TI-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tri_count <= 11'd0;
      epsilon   <= 17'd7;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtc_pkg::REG_TRI_COUNT: tri_count <= cfg_data[10:0];
        rtc_pkg::REG_EPSILON:   epsilon   <= cfg_data;
        default: ;
      endcase
    end
  end

  // third vertex straight from the memory output
  assign vc = ok_c ? pos_q : '0;

  // operand select per step
  assign issue = (state == S_MUL) || (state == S_HP);
  always_comb begin
    case (step)
      5'd0:  begin ma = ab.y; mb = ao.z; end
      5'd1:  begin ma = ab.z; mb = ao.y; end
      5'd2:  begin ma = ab.z; mb = ao.x; end
      5'd3:  begin ma = ab.x; mb = ao.z; end
      5'd4:  begin ma = ab.x; mb = ao.y; end
      5'd5:  begin ma = ab.y; mb = ao.x; end
      5'd6:  begin ma = ac.y; mb = dv.z; end
      5'd7:  begin ma = ac.z; mb = dv.y; end
      5'd8:  begin ma = ac.z; mb = dv.x; end
      5'd9:  begin ma = ac.x; mb = dv.z; end
      5'd10: begin ma = ac.x; mb = dv.y; end
      5'd11: begin ma = ac.y; mb = dv.x; end
      5'd12: begin ma = ab.x; mb = c2.x; end
      5'd13: begin ma = ab.y; mb = c2.y; end
      5'd14: begin ma = ab.z; mb = c2.z; end
      5'd15: begin ma = ac.x; mb = c1.x; end
      5'd16: begin ma = ac.y; mb = c1.y; end
      5'd17: begin ma = ac.z; mb = c1.z; end
      5'd18: begin ma = ao.x; mb = c2.x; end
      5'd19: begin ma = ao.y; mb = c2.y; end
      5'd20: begin ma = ao.z; mb = c2.z; end
      5'd21: begin ma = dv.x; mb = c1.x; end
      5'd22: begin ma = dv.y; mb = c1.y; end
      5'd23: begin ma = dv.z; mb = c1.z; end
      5'd24: begin ma = dv.x; mb = $signed({1'b0, best}); end
      5'd25: begin ma = dv.y; mb = $signed({1'b0, best}); end
      5'd26: begin ma = dv.z; mb = $signed({1'b0, best}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign aop       = rtc_pkg::acc_op(acc_step);
  assign cross_val = rtc_pkg::sat32((acc - 65'(prod)) >>> rtc_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= issue;
    end
    acc_step <= step;
    prod     <= ma * mb;
    if (acc_en) begin
      case (aop.kind)
        rtc_pkg::K_CROSS_FIRST: acc <= 65'(prod);
        rtc_pkg::K_CROSS_END: begin
          case (aop.dst)
            3'd0:    c1.x <= cross_val;
            3'd1:    c1.y <= cross_val;
            3'd2:    c1.z <= cross_val;
            3'd3:    c2.x <= cross_val;
            3'd4:    c2.y <= cross_val;
            default: c2.z <= cross_val;
          endcase
        end
        rtc_pkg::K_DOT_FIRST: acc <= rtc_pkg::fsh(prod);
        rtc_pkg::K_DOT_MID:   acc <= acc + rtc_pkg::fsh(prod);
        rtc_pkg::K_DOT_END:   dotr[aop.dst[1:0]] <= rtc_pkg::sat32(acc + rtc_pkg::fsh(prod));
        rtc_pkg::K_HIT: begin
          case (aop.dst)
            3'd0:    hp[0] <= rtc_pkg::sat32(65'(org.x) + rtc_pkg::fsh(prod));
            3'd1:    hp[1] <= rtc_pkg::sat32(65'(org.y) + rtc_pkg::fsh(prod));
            default: hp[2] <= rtc_pkg::sat32(65'(org.z) + rtc_pkg::fsh(prod));
          endcase
        end
        default: ;
      endcase
    end
  end

  // t numerator is negated; u and v follow on the same divider
  always_comb begin
    div_start = 1'b0;
    div_num   = -33'(dotr[1]);
    if (state == S_CHK) begin
      div_start = (dotr[0] != 32'sd0);
    end else if (state == S_DIV && div_done) begin
      if (sel == 2'd0) begin
        div_start = (quo >= $signed({32'd0, epsilon}));
        div_num   = 33'(dotr[2]);
      end else if (sel == 2'd1) begin
        div_start = (quo >= 0) && (quo <= ONE_Q);
        div_num   = 33'(dotr[3]);
      end
    end
  end

  rtc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dotr[0]),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == rtc_pkg::CMD_TRACE) begin
              org   <= {coord_x, coord_y, coord_z};
              dv    <= {dir_x, dir_y, dir_z};
              best  <= max_distance;
              found <= 1'b0;
              idx   <= '0;
              count <= (32'(tri_count) > MAX_TRIANGLES) ? TC'(MAX_TRIANGLES) : TC'(tri_count);
              state <= (tri_count == 11'd0) ? S_FIN : S_TRI;
            end else begin
              done         <= 1'b1;
              hit          <= 1'b0;
              hit_distance <= '0;
              hit_x        <= '0;
              hit_y        <= '0;
              hit_z        <= '0;
              normal_x     <= '0;
              normal_y     <= '0;
              normal_z     <= '0;
              tri_index    <= '0;
            end
          end
        end
        S_TRI: state <= S_VA;
        S_VA: begin
          crn_a <= tri_q[10:0];
          crn_b <= tri_q[21:11];
          crn_c <= tri_q[32:22];
          ok_a  <= 32'(tri_q[10:0]) < MAX_VERTICES;
          ok_b  <= 32'(tri_q[21:11]) < MAX_VERTICES;
          ok_c  <= 32'(tri_q[32:22]) < MAX_VERTICES;
          state <= S_VB;
        end
        S_VB: begin
          va    <= ok_a ? pos_q : '0;
          state <= S_VC;
        end
        S_VC: begin
          vb    <= ok_b ? pos_q : '0;
          state <= S_SUB;
        end
        S_SUB: begin
          ab.x  <= rtc_pkg::sat32(65'(va.x) - 65'(vb.x));
          ab.y  <= rtc_pkg::sat32(65'(va.y) - 65'(vb.y));
          ab.z  <= rtc_pkg::sat32(65'(va.z) - 65'(vb.z));
          ac.x  <= rtc_pkg::sat32(65'(va.x) - 65'(vc.x));
          ac.y  <= rtc_pkg::sat32(65'(va.y) - 65'(vc.y));
          ac.z  <= rtc_pkg::sat32(65'(va.z) - 65'(vc.z));
          ao.x  <= rtc_pkg::sat32(65'(va.x) - 65'(org.x));
          ao.y  <= rtc_pkg::sat32(65'(va.y) - 65'(org.y));
          ao.z  <= rtc_pkg::sat32(65'(va.z) - 65'(org.z));
          step  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          step <= step + 1'b1;
          if (step == rtc_pkg::STEP_TEST_LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_CHK;
        S_CHK: begin
          sel   <= 2'd0;
          state <= div_start ? S_DIV : S_NEXT;
        end
        S_DIV: begin
          if (div_done) begin
            case (sel)
              2'd0: begin
                t_q   <= quo;
                sel   <= 2'd1;
                state <= div_start ? S_DIV : S_NEXT;
              end
              2'd1: begin
                u_q   <= quo;
                sel   <= 2'd2;
                state <= div_start ? S_DIV : S_NEXT;
              end
              default: begin
                if ((quo >= 0) && (quo <= ONE_Q - u_q) &&
                    (t_q < $signed({18'd0, best}))) begin
                  best   <= t_q[30:0];
                  best_i <= idx[TI-1:0];
                  best_a <= crn_a;
                  found  <= 1'b1;
                end
                state <= S_NEXT;
              end
            endcase
          end
        end
        S_NEXT: begin
          if (idx + 1'b1 == count) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_TRI;
          end
        end
        S_FIN: begin
          if (found) begin
            step  <= rtc_pkg::STEP_HIT_FIRST;
            state <= S_HP;
          end else begin
            done         <= 1'b1;
            hit          <= 1'b0;
            hit_distance <= '0;
            hit_x        <= '0;
            hit_y        <= '0;
            hit_z        <= '0;
            normal_x     <= '0;
            normal_y     <= '0;
            normal_z     <= '0;
            tri_index    <= '0;
            state        <= S_IDLE;
          end
        end
        S_HP: begin
          step <= step + 1'b1;
          if (step == rtc_pkg::STEP_HIT_LAST) begin
            state <= S_HPDRAIN;
          end
        end
        S_HPDRAIN: state <= S_OUT;
        S_OUT: begin
          done         <= 1'b1;
          hit          <= 1'b1;
          hit_distance <= best;
          hit_x        <= hp[0];
          hit_y        <= hp[1];
          hit_z        <= hp[2];
          // corner beyond the store reads as a zero normal
          normal_x     <= (32'(best_a) < MAX_VERTICES) ? nrm_q.x : 32'sd0;
          normal_y     <= (32'(best_a) < MAX_VERTICES) ? nrm_q.y : 32'sd0;
          normal_z     <= (32'(best_a) < MAX_VERTICES) ? nrm_q.z : 32'sd0;
          tri_index    <= 10'(best_i);
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
